### sv/lmpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_pkg
// Shared constants, types and color expansion functions of the LED matrix
// pixel mapper.
// ----------------------------------------------------------------------------
package lmpm_pkg;

  localparam int Columns    = 32;
  localparam int Rows       = 8;
  localparam int PalEntries = 256;

  localparam int PalAddrW = 8;
  localparam int ColorW   = 16;
  localparam int LedW     = 8;

  // Request codes.
  localparam logic [1:0] ReqPalWrite = 2'd0;
  localparam logic [1:0] ReqIndexed  = 2'd1;
  localparam logic [1:0] ReqDirect   = 2'd2;

  // Configuration register indexes.
  localparam logic CfgTranspEnable = 1'b0;
  localparam logic CfgTranspIndex  = 1'b1;

  // Scaled reciprocals of 31 and 63 with a 20-bit fraction; the error stays
  // below one step of the truncated quotient over the whole input range.
  localparam logic [31:0] Recip5 = 32'd33826;
  localparam logic [31:0] Recip6 = 32'd16645;

  typedef struct packed {
    logic [LedW-1:0]   led;
    logic              opaque;
    logic              from_palette;
    logic              pal_hit;
    logic [ColorW-1:0] color;
  } pix_t;

  // v * 255 / 31, truncated.
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [12:0] scaled;
    logic [31:0] prod;
    scaled = {v, 8'd0} - 13'(v);
    prod   = 32'(scaled) * Recip5;
    return prod[27:20];
  endfunction

  // v * 255 / 63, truncated.
  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [13:0] scaled;
    logic [31:0] prod;
    scaled = {v, 8'd0} - 14'(v);
    prod   = 32'(scaled) * Recip6;
    return prod[27:20];
  endfunction

endpackage

### sv/led_matrix_pixel_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_pixel_mapper
// Maps palette loads and pixel draws onto a column-serpentine LED matrix.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low. An item passes
// the pixel stage, which registers the synchronous palette read and the
// position mapping, then the RGB565 to RGB888 expansion into the output
// register. Palette loads and pixels outside the matrix give no result. A
// palette load is written at the edge where it is accepted, so a draw accepted
// in the very next cycle already sees the new entry. Stall from the output
// side propagates back to in_stall only when both pipeline stages are full.
module led_matrix_pixel_mapper (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [7:0]         pixel_index,
  input  logic [15:0]        color565,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         led_index,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha
);

  logic                        transp_enable;
  logic [7:0]                  transp_index;
  logic                        accept;
  logic                        is_draw;
  logic                        in_matrix;
  logic                        pal_hit;
  logic [7:0]                  row_off;
  logic                        s1_valid;
  lmpm_pkg::pix_t              s1_pix;
  lmpm_pkg::pix_t              pix_next;
  logic                        take;
  logic [lmpm_pkg::ColorW-1:0] pal_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      transp_enable <= 1'b0;
      transp_index  <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        lmpm_pkg::CfgTranspEnable: transp_enable <= cfg_data[0];
        lmpm_pkg::CfgTranspIndex:  transp_index  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = s1_valid && !take;
  assign accept    = in_valid && !in_stall;
  assign is_draw   = (req_type == lmpm_pkg::ReqIndexed) || (req_type == lmpm_pkg::ReqDirect);
  assign in_matrix = !pos_x[15] && !pos_y[15]
                  && ($unsigned(pos_x) < 16'(lmpm_pkg::Columns))
                  && ($unsigned(pos_y) < 16'(lmpm_pkg::Rows));
  assign pal_hit   = {1'b0, pixel_index} < 9'(lmpm_pkg::PalEntries);

  // Even columns count upward from the bottom row.
  assign row_off = pos_x[0] ? pos_y[7:0] : 8'(lmpm_pkg::Rows - 1) - pos_y[7:0];

  always_comb begin
    pix_next.led          = 8'(pos_x[7:0] * 8'(lmpm_pkg::Rows)) + row_off;
    pix_next.from_palette = (req_type == lmpm_pkg::ReqIndexed);
    pix_next.opaque       = (req_type == lmpm_pkg::ReqIndexed)
                         && !(transp_enable && (pixel_index == transp_index));
    pix_next.pal_hit      = pal_hit;
    pix_next.color        = color565;
  end

  lmpm_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (accept && (req_type == lmpm_pkg::ReqPalWrite) && pal_hit),
    .wr_addr (pixel_index),
    .wr_data (color565),
    .rd_en   (accept && (req_type == lmpm_pkg::ReqIndexed) && pal_hit),
    .rd_addr (pixel_index),
    .rd_data (pal_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || take) begin
      s1_valid <= accept && is_draw && in_matrix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix_next;
    end
  end

  lmpm_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (s1_valid),
    .pix       (s1_pix),
    .pal_data  (pal_data),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha)
  );

  // A palette load never reaches the pixel stage.
  assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == lmpm_pkg::ReqPalWrite) |=> !s1_valid)
    else $error("palette load entered the pixel stage");

  // A pixel held by a stalled output stage keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !take |=> s1_valid && $stable(s1_pix))
    else $error("held pixel changed while output stalled");

  // A new result only comes from a full pixel stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a pixel in flight");

  // Input stall only when the pixel stage is occupied.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");

endmodule

### sv/lmpm_palette_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_palette_ram
// Single-port-write, single-port-read palette memory with registered read
// data. The read data holds until the next read.
// ----------------------------------------------------------------------------
module lmpm_palette_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [lmpm_pkg::PalAddrW-1:0] wr_addr,
  input  logic [lmpm_pkg::ColorW-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [lmpm_pkg::PalAddrW-1:0] rd_addr,
  output logic [lmpm_pkg::ColorW-1:0]   rd_data
);

  logic [lmpm_pkg::ColorW-1:0] mem [lmpm_pkg::PalEntries];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/lmpm_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmpm_expand
// Output stage: selects the pixel color, expands RGB565 to RGB888 and holds
// the result item in the output register until it is taken.
// ----------------------------------------------------------------------------
module lmpm_expand (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  input  lmpm_pkg::pix_t             pix,
  input  logic [lmpm_pkg::ColorW-1:0] pal_data,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 led_index,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue,
  output logic [7:0]                 alpha
);

  logic [lmpm_pkg::ColorW-1:0] color;

  assign take = !out_valid || !out_stall;

  always_comb begin
    if (!pix.from_palette) begin
      color = pix.color;
    end else if (pix.pal_hit) begin
      color = pal_data;
    end else begin
      color = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pix_valid) begin
      led_index <= pix.led;
      red       <= lmpm_pkg::exp5(color[15:11]);
      green     <= lmpm_pkg::exp6(color[10:5]);
      blue      <= lmpm_pkg::exp5(color[4:0]);
      alpha     <= pix.opaque ? 8'd255 : 8'd0;
    end
  end

endmodule

### tb/led_matrix_pixel_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_pixel_mapper_tb
// Drives palette loads, indexed draws and direct draws into the pixel mapper.
// It predicts the LED index and the RGB888/alpha of every pixel that falls
// inside the matrix, and checks each result item in order. Both sides idle
// in random bursts, and once the receiver holds off long enough to back the
// block up into its input.
// ----------------------------------------------------------------------------
module led_matrix_pixel_mapper_tb;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int RandomPerPhase = 200;

  typedef struct {
    logic [1:0]         req;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         idx;
    logic [15:0]        col;
  } pixel_req_t;

  typedef struct {
    logic [7:0] led;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } led_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = lmpm_pkg::ReqPalWrite;
  logic signed [15:0] pos_x = 16'sd0;
  logic signed [15:0] pos_y = 16'sd0;
  logic [7:0] pixel_index = 8'd0;
  logic [15:0] color565 = 16'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] led_index, red, green, blue, alpha;

  led_matrix_pixel_mapper dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y),
    .pixel_index(pixel_index), .color565(color565),
    .out_valid(out_valid), .out_stall(out_stall),
    .led_index(led_index), .red(red), .green(green), .blue(blue), .alpha(alpha)
  );

  pixel_req_t  req_queue[$];
  led_result_t led_expect_q[$];
  pixel_req_t  cur_req;

  // Shadow of the block state; the palette is updated as items are accepted.
  logic [15:0] pal_shadow[lmpm_pkg::PalEntries];
  logic        tr_en_shadow = 1'b0;
  logic [7:0]  tr_idx_shadow = 8'd0;

  // Generation side: which palette entries are loaded by the queued stream.
  bit   written[256];
  int   written_list[$];
  logic [7:0] gen_tr_idx = 8'd0;

  int  errors = 0;
  int  n_accepted = 0;
  bit  gaps_on = 1'b1;
  logic rx_hold = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return 8'((int'(v) * 255) / 31);
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return 8'((int'(v) * 255) / 63);
  endfunction

  // Applies one accepted item to the shadow state and queues its result, if any.
  function automatic void map_request(input pixel_req_t it);
    led_result_t res;
    logic [15:0] c;
    int x, y, led;
    if (it.req == lmpm_pkg::ReqPalWrite) begin
      if (int'(it.idx) < lmpm_pkg::PalEntries) pal_shadow[it.idx] = it.col;
      return;
    end
    if (it.req != lmpm_pkg::ReqIndexed && it.req != lmpm_pkg::ReqDirect) return;
    x = it.x;
    y = it.y;
    if (x < 0 || y < 0 || x >= lmpm_pkg::Columns || y >= lmpm_pkg::Rows) return;
    if (it.req == lmpm_pkg::ReqIndexed) begin
      c = (int'(it.idx) < lmpm_pkg::PalEntries) ? pal_shadow[it.idx] : 16'd0;
      res.a = (tr_en_shadow && it.idx == tr_idx_shadow) ? 8'd0 : 8'd255;
    end else begin
      c = it.col;
      res.a = 8'd0;
    end
    // Even columns count from the bottom row up.
    if (x % 2 == 0) led = x * lmpm_pkg::Rows + (lmpm_pkg::Rows - 1 - y);
    else led = x * lmpm_pkg::Rows + y;
    res.led = 8'(led);
    res.r = widen5(c[15:11]);
    res.g = widen6(c[10:5]);
    res.b = widen5(c[4:0]);
    led_expect_q.push_back(res);
  endfunction

  // Driver: offers the next queued item once the current one is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        map_request(cur_req);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          cur_req = req_queue.pop_front();
          req_type <= cur_req.req;
          pos_x <= cur_req.x;
          pos_y <= cur_req.y;
          pixel_index <= cur_req.idx;
          color565 <= cur_req.col;
          in_valid <= 1'b1;
          if (gaps_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result and drives the output stall.
  always @(posedge clk) begin
    led_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (led_expect_q.size() == 0) begin
          report_mismatch($sformatf("result item led %0d with nothing expected", led_index));
        end else begin
          want = led_expect_q.pop_front();
          if (led_index !== want.led)
            report_mismatch($sformatf("led_index %0d, want %0d", led_index, want.led));
          if (red !== want.r)
            report_mismatch($sformatf("red %0d, want %0d (led %0d)", red, want.r, want.led));
          if (green !== want.g)
            report_mismatch($sformatf("green %0d, want %0d (led %0d)", green, want.g, want.led));
          if (blue !== want.b)
            report_mismatch($sformatf("blue %0d, want %0d (led %0d)", blue, want.b, want.led));
          if (alpha !== want.a)
            report_mismatch($sformatf("alpha %0d, want %0d (led %0d)", alpha, want.a, want.led));
        end
      end
      if (rx_hold) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering items.
  initial begin
    while (n_accepted < 300) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_req(input logic [1:0] req, input logic signed [15:0] x,
                          input logic signed [15:0] y, input logic [7:0] idx,
                          input logic [15:0] col);
    pixel_req_t it;
    it.req = req;
    it.x = x;
    it.y = y;
    it.idx = idx;
    it.col = col;
    if (req == lmpm_pkg::ReqPalWrite && !written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(int'(idx));
    end
    req_queue.push_back(it);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == lmpm_pkg::CfgTranspEnable) tr_en_shadow = data[0];
    else tr_idx_shadow = data;
    if (idx == lmpm_pkg::CfgTranspIndex) gen_tr_idx = data;
  endtask

  // Waits until every queued item is taken and every result has come back,
  // then lets the pipeline run empty since dropped items leave no trace.
  task automatic drain;
    do @(posedge clk);
    while (req_queue.size() > 0 || in_valid || led_expect_q.size() > 0);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_coord(input int lim);
    case ($urandom_range(0, 11))
      0: return 16'($urandom);
      1: return 16'(-int'($urandom_range(1, 3)));
      2: return 16'(lim + int'($urandom_range(0, 2)));
      3: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(0, lim - 1));
    endcase
  endfunction

  function automatic logic [15:0] rnd_color;
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] loaded_index;
    return 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  task automatic gen_random(input int count);
    int k, pick;
    logic [7:0] idx;
    // Make sure the transparent entry is loaded so it can be drawn.
    push_req(lmpm_pkg::ReqPalWrite, 16'sd0, 16'sd0, gen_tr_idx, rnd_color());
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        push_req(lmpm_pkg::ReqPalWrite, 16'($urandom), 16'($urandom), 8'($urandom),
                 rnd_color());
      end else if (pick < 55) begin
        idx = ($urandom_range(0, 3) == 0) ? gen_tr_idx : loaded_index();
        push_req(lmpm_pkg::ReqIndexed, rnd_coord(lmpm_pkg::Columns),
                 rnd_coord(lmpm_pkg::Rows), idx, 16'($urandom));
      end else if (pick < 92) begin
        push_req(lmpm_pkg::ReqDirect, rnd_coord(lmpm_pkg::Columns),
                 rnd_coord(lmpm_pkg::Rows), loaded_index(), rnd_color());
      end else begin
        push_req(ReqUnused, 16'($urandom), 16'($urandom), loaded_index(), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_reg(lmpm_pkg::CfgTranspEnable, 8'd0);
    write_reg(lmpm_pkg::CfgTranspIndex, 8'd0);

    // Directed: palette extremes, each draw kind, matrix corners and edges.
    push_req(lmpm_pkg::ReqPalWrite, 16'sd0, 16'sd0, 8'd0, 16'hffff);
    push_req(lmpm_pkg::ReqPalWrite, 16'sd0, 16'sd0, 8'd255, 16'h0000);
    push_req(lmpm_pkg::ReqPalWrite, 16'sd0, 16'sd0, 8'd1, 16'hf800);
    push_req(lmpm_pkg::ReqPalWrite, 16'sd0, 16'sd0, 8'd2, 16'h07e0);
    push_req(lmpm_pkg::ReqPalWrite, 16'sd0, 16'sd0, 8'd3, 16'h001f);
    push_req(lmpm_pkg::ReqIndexed, 16'sd0, 16'sd0, 8'd0, 16'h0000);
    push_req(lmpm_pkg::ReqIndexed, 16'sd31, 16'sd7, 8'd255, 16'hffff);
    push_req(lmpm_pkg::ReqIndexed, 16'sd1, 16'sd0, 8'd1, 16'h0000);
    push_req(lmpm_pkg::ReqIndexed, 16'sd0, 16'sd7, 8'd2, 16'h0000);
    push_req(lmpm_pkg::ReqIndexed, 16'sd31, 16'sd0, 8'd3, 16'h0000);
    push_req(lmpm_pkg::ReqDirect, 16'sd0, 16'sd0, 8'd0, 16'hffff);
    push_req(lmpm_pkg::ReqDirect, 16'sd30, 16'sd3, 8'd0, 16'h0000);
    push_req(lmpm_pkg::ReqDirect, 16'sd15, 16'sd4, 8'd0, 16'ha5a5);
    push_req(lmpm_pkg::ReqDirect, -16'sd1, 16'sd0, 8'd0, 16'hffff);
    push_req(lmpm_pkg::ReqDirect, 16'sd32, 16'sd0, 8'd0, 16'hffff);
    push_req(lmpm_pkg::ReqDirect, 16'sd0, 16'sd8, 8'd0, 16'hffff);
    push_req(lmpm_pkg::ReqIndexed, 16'sd0, 16'sh8000, 8'd0, 16'h0000);
    push_req(lmpm_pkg::ReqDirect, 16'sh7fff, 16'sh7fff, 8'd0, 16'hffff);
    push_req(ReqUnused, 16'sd5, 16'sd5, 8'd0, 16'h1234);
    // A load followed at once by a draw of the same entry.
    push_req(lmpm_pkg::ReqPalWrite, 16'sd0, 16'sd0, 8'd128, 16'h8410);
    push_req(lmpm_pkg::ReqIndexed, 16'sd2, 16'sd2, 8'd128, 16'h0000);
    drain();

    write_reg(lmpm_pkg::CfgTranspEnable, 8'd1);
    write_reg(lmpm_pkg::CfgTranspIndex, 8'd128);
    push_req(lmpm_pkg::ReqIndexed, 16'sd4, 16'sd6, 8'd128, 16'h0000);
    push_req(lmpm_pkg::ReqIndexed, 16'sd5, 16'sd6, 8'd0, 16'h0000);
    push_req(lmpm_pkg::ReqDirect, 16'sd6, 16'sd1, 8'd128, 16'h7bef);
    drain();

    gen_random(RandomPerPhase);
    drain();
    write_reg(lmpm_pkg::CfgTranspIndex, 8'd255);
    gen_random(RandomPerPhase);
    drain();
    write_reg(lmpm_pkg::CfgTranspIndex, 8'($urandom));
    gen_random(RandomPerPhase);
    drain();
    write_reg(lmpm_pkg::CfgTranspEnable, 8'd0);
    write_reg(lmpm_pkg::CfgTranspIndex, 8'($urandom));
    gen_random(RandomPerPhase);
    drain();
    write_reg(lmpm_pkg::CfgTranspEnable, 8'd1);
    write_reg(lmpm_pkg::CfgTranspIndex, 8'($urandom));
    gaps_on = 1'b0;
    gen_random(RandomPerPhase);
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0 && led_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### led_matrix_pixel_mapper.f
sv/lmpm_pkg.sv
sv/lmpm_palette_ram.sv
sv/lmpm_expand.sv
sv/led_matrix_pixel_mapper.sv
tb/led_matrix_pixel_mapper_tb.sv
